### hdl/cqs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the circular queue with search.
// No dependencies; used by cqs_cell and circular_queue_with_search_top.
package cqs_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int SLOT_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_FINISH
    } fsm_t;

    // Broadcast controls for the row of slot cells
    typedef struct packed {
        logic wr;    // write key into the selected cell
        logic load;  // capture match flags, place token on the selected cell
        logic step;  // hand the token to the next cell
    } cell_ctrl_t;

endpackage

### hdl/cqs_cell.sv
`timescale 1ns / 1ps
// One ring slot: stored word, match flag and search token.
// Depends on cqs_pkg.
module cqs_cell
    import cqs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic                     sel,
    input  logic                     is_end,
    input  logic signed [DATA_W-1:0] key,
    input  logic                     tok_in,
    output logic                     tok_carry,
    output logic                     tok_wrap,
    output logic                     tok,
    output logic                     hit,
    output logic signed [DATA_W-1:0] rd_word
);

    logic signed [DATA_W-1:0] word_reg;
    logic                     match_reg;
    logic                     tok_reg;
    logic                     tok_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr && sel)
        begin
            word_reg <= key;
        end
        if (ctrl.load)
        begin
            match_reg <= (word_reg == key);
        end
    end

    always_comb
    begin
        tok_next = tok_reg;
        if (ctrl.load)
        begin
            tok_next = sel;
        end
        else if (ctrl.step)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // last cell in use sends the token back to cell 0
    assign tok_carry = tok_reg & ~is_end;
    assign tok_wrap  = tok_reg & is_end;
    assign tok       = tok_reg;
    assign hit       = tok_reg & match_reg;
    assign rd_word   = sel ? word_reg : '0;

endmodule

### hdl/circular_queue_with_search_top.sv
`timescale 1ns / 1ps
// Enqueue, dequeue, peek and empty/full results: in the output register in the cycle after the input beat.
// Search: the token walks one slot cell per cycle, except while a held match beat waits
// for a busy output register. Input is held off during a search.
// A new item is taken whenever no search runs and the output register is free or draining.
// Reset: empty queue, capacity 16; slot words are not cleared (no clearing pass).
// Depends on cqs_pkg and cqs_cell.
module circular_queue_with_search_top
    import cqs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data,
    output logic [SLOT_W-1:0]        slot,
    output logic                     last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    fsm_t                     state_reg, state_next;
    logic [CAP_W-1:0]         cap_reg;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [PTR_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [PTR_W-1:0]         pend_slot_reg, pend_slot_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic                     last_reg, last_next;
    logic                     out_load;

    logic [CW-1:0]            cap_ext;
    logic [CNT_W-1:0]         cap_eff;
    logic                     out_free;
    logic                     accept;
    req_t                     req;
    logic [PTR_W-1:0]         sel_idx;
    cell_ctrl_t               ctrl;

    logic [DEPTH-1:0]         cell_sel;
    logic [DEPTH-1:0]         cell_end;
    logic [DEPTH-1:0]         cell_tok_in;
    logic [DEPTH-1:0]         cell_carry;
    logic [DEPTH-1:0]         cell_wrap;
    logic [DEPTH-1:0]         cell_tok;
    logic [DEPTH-1:0]         cell_hit;
    logic signed [DATA_W-1:0] cell_rd [DEPTH];
    logic signed [DATA_W-1:0] rd_word;
    logic                     hit;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= c) ? '0 : n[PTR_W-1:0];
    endfunction

    // capacity 0 acts as 1, above DEPTH acts as DEPTH
    always_comb
    begin
        cap_ext = CW'(cap_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_ext > CW'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_ext[CNT_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == FSM_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign req      = req_t'(req_type);
    assign sel_idx  = (req == REQ_ENQ) ? tail_reg : head_reg;

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_sel[gi] = (sel_idx == PTR_W'(gi));
            assign cell_end[gi] = (cap_eff == CNT_W'(gi + 1));
            if (gi == 0)
            begin : g_head
                assign cell_tok_in[gi] = |cell_wrap;
            end
            else
            begin : g_body
                assign cell_tok_in[gi] = cell_carry[gi-1];
            end

            cqs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .sel       (cell_sel[gi]),
                .is_end    (cell_end[gi]),
                .key       (value),
                .tok_in    (cell_tok_in[gi]),
                .tok_carry (cell_carry[gi]),
                .tok_wrap  (cell_wrap[gi]),
                .tok       (cell_tok[gi]),
                .hit       (cell_hit[gi]),
                .rd_word   (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    assign hit = |cell_hit;

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        out_load        = 1'b0;
        status_next     = status_reg;
        data_next       = data_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;
        ctrl            = '0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    out_load    = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    slot_next   = '0;
                    last_next   = 1'b1;
                    if (req == REQ_ENQ)
                    begin
                        if (occ_reg >= cap_eff)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.wr   = 1'b1;
                            slot_next = SLOT_W'(tail_reg);
                            tail_next = adv(tail_reg, cap_eff);
                            occ_next  = occ_reg + CNT_W'(1);
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (req == REQ_DEQ)
                    begin
                        data_next = rd_word;
                        occ_next  = occ_reg - CNT_W'(1);
                        if (occ_reg == CNT_W'(1))
                        begin
                            // queue drained: pointers return to slot 0
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                        begin
                            head_next = adv(head_reg, cap_eff);
                        end
                    end
                    else if (req == REQ_PEEK)
                    begin
                        data_next = rd_word;
                    end
                    else
                    begin
                        out_load        = 1'b0;
                        ctrl.load       = 1'b1;
                        idx_next        = head_reg;
                        rem_next        = occ_reg;
                        pend_valid_next = 1'b0;
                        state_next      = FSM_SEARCH;
                    end
                end
            end

            FSM_SEARCH:
            begin
                // a match is held back one hit so the final one can carry last
                if (!(hit && pend_valid_reg) || out_free)
                begin
                    ctrl.step = 1'b1;
                    if (hit && pend_valid_reg)
                    begin
                        out_load    = 1'b1;
                        status_next = ST_OK;
                        data_next   = '0;
                        slot_next   = SLOT_W'(pend_slot_reg);
                        last_next   = 1'b0;
                    end
                    if (hit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                    end
                    idx_next = adv(idx_reg, cap_eff);
                    rem_next = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = FSM_FINISH;
                    end
                end
            end

            FSM_FINISH:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    data_next = '0;
                    last_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        status_next = ST_OK;
                        slot_next   = SLOT_W'(pend_slot_reg);
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                        slot_next   = '0;
                    end
                    state_next = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            cap_reg        <= CAP_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            idx_reg        <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                // capacity write empties the queue, slot words kept
                cap_reg  <= cfg_wr_data;
                head_reg <= '0;
                tail_reg <= '0;
                occ_reg  <= '0;
            end
            else
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

    // checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cap_eff)
        else $error("occupancy above capacity");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(head_reg) < cap_eff) && (CNT_W'(tail_reg) < cap_eff))
        else $error("ring pointer outside capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with pointers off slot 0");

    a_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_SEARCH) |-> $onehot(cell_tok) && (rem_reg != '0))
        else $error("search token lost or walk count exhausted");

endmodule

### test/cqs_queue_checker.sv
`timescale 1ns / 1ps
// Reply checker for circular_queue_with_search_top: keeps its own ring, pointers and
// capacity, predicts the replies of every request beat and compares every reply beat.
// Depends on cqs_pkg.
module cqs_queue_checker
    import cqs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [1:0]               status,
    input  logic signed [DATA_W-1:0] data,
    input  logic [SLOT_W-1:0]        slot,
    input  logic                     last,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] data;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } reply_t;

    reply_t            queue_replies[$];
    logic [DATA_W-1:0] ring [DEPTH];
    logic [CAP_W-1:0]  cap_reg;
    int unsigned       front;
    int unsigned       rear;
    int unsigned       fill;

    // 0 behaves as 1, anything above DEPTH as DEPTH
    function automatic int unsigned usable_slots();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > DEPTH)
            return DEPTH;
        return cap_reg;
    endfunction

    function automatic int unsigned wrap_next(int unsigned idx, int unsigned cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function automatic void add_reply(status_t st, logic [DATA_W-1:0] word,
                                      int unsigned idx, logic fin);
        reply_t r;
        r.status = st;
        r.data   = word;
        r.slot   = SLOT_W'(idx);
        r.last   = fin;
        queue_replies.push_back(r);
    endfunction

    function automatic void predict_request(req_t req, logic [DATA_W-1:0] word);
        int unsigned cap;
        int unsigned h;
        int unsigned t;
        int unsigned occ;
        int unsigned idx;
        int unsigned hits;
        cap = usable_slots();
        h   = (front < cap) ? front : 0;
        t   = (rear < cap) ? rear : 0;
        occ = (fill <= cap) ? fill : cap;
        if (req == REQ_ENQ)
        begin
            if (occ >= cap)
                add_reply(ST_FULL, '0, 0, 1'b1);
            else
            begin
                ring[t] = word;
                add_reply(ST_OK, '0, t, 1'b1);
                rear = wrap_next(t, cap);
                fill = occ + 1;
            end
        end
        else if (occ == 0)
            add_reply(ST_EMPTY, '0, 0, 1'b1);
        else if (req == REQ_DEQ)
        begin
            add_reply(ST_OK, ring[h], 0, 1'b1);
            fill = occ - 1;
            // last word gone: both pointers go back to slot 0
            if (fill == 0)
            begin
                front = 0;
                rear  = 0;
            end
            else
                front = wrap_next(h, cap);
        end
        else if (req == REQ_PEEK)
            add_reply(ST_OK, ring[h], 0, 1'b1);
        else
        begin
            hits = 0;
            idx  = h;
            repeat (occ)
            begin
                if (ring[idx] == word)
                begin
                    add_reply(ST_OK, '0, idx, 1'b0);
                    hits++;
                end
                idx = wrap_next(idx, cap);
            end
            if (hits == 0)
                add_reply(ST_NOTFOUND, '0, 0, 1'b1);
            else
                queue_replies[queue_replies.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h",
                     $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            queue_replies.delete();
            cap_reg    = CAP_RESET;
            front      = 0;
            rear       = 0;
            fill       = 0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (queue_replies.size() == 0)
                begin
                    $display({"%0t: unexpected reply beat: expected none, ",
                              "got status %0d data 'h%0h slot %0d last %0d"},
                             $time, status, data, slot, last);
                    fail_count++;
                end
                else
                begin
                    want = queue_replies.pop_front();
                    check_field("status", want.status, status);
                    check_field("data", want.data, data);
                    check_field("slot", want.slot, slot);
                    check_field("last", want.last, last);
                end
            end
            // a capacity write empties the queue, slot contents stay
            if (cfg_wr_en)
            begin
                cap_reg = cfg_wr_data;
                front   = 0;
                rear    = 0;
                fill    = 0;
            end
            if (in_valid && in_ready)
                predict_request(req_t'(req_type), value);
            pending = queue_replies.size();
        end
    end

endmodule

### test/tb_circular_queue_with_search_top.sv
`timescale 1ns / 1ps
// Testbench top for circular_queue_with_search_top: drives requests and capacity writes,
// paces the reply side and gives the verdict. Depends on cqs_pkg and cqs_queue_checker.
module tb_circular_queue_with_search_top;
    import cqs_pkg::*;

    localparam int DEPTH       = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 25;
    localparam int RX_HOLD     = 300;
    localparam int STALL_LIMIT = 2000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CAP_W-1:0]         cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [SLOT_W-1:0]        slot;
    logic                     last;

    int fail_count;
    int pending;
    int stall_cycles;
    bit tx_no_idle;
    bit rx_no_idle;
    bit hold_armed;
    bit hold_taken;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    circular_queue_with_search_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data        (data),
        .slot        (slot),
        .last        (last)
    );

    cqs_queue_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data        (data),
        .slot        (slot),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // watchdog: cycles in a row without any beat or register write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // reply side: random gap before each beat (none in no-idle phases), one long hold-off when armed
    initial
    begin : rx_side
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_no_idle ? 0 : $urandom_range(0, 16);
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                gap        = RX_HOLD;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic send_item(req_t op, logic [DATA_W-1:0] word);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        value    <= word;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering, wait for every expected reply, then let the block settle
    task automatic drain(int settle);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain(4);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        req_t              op;
        logic [DATA_W-1:0] word;
        logic [CAP_W-1:0]  phase_caps [PHASES];
        int unsigned       cap_used;
        int unsigned       r;
        int                ph;
        int                k;

        phase_caps  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd17, 5'd2, 5'd16};
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        req_type    = REQ_ENQ;
        value       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue at reset capacity, extreme words, double match, no match
        send_item(REQ_DEQ, '0);
        send_item(REQ_PEEK, '0);
        send_item(REQ_SEARCH, '0);
        send_item(REQ_ENQ, 32'h8000_0000);
        send_item(REQ_ENQ, 32'h7FFF_FFFF);
        send_item(REQ_ENQ, '1);
        send_item(REQ_ENQ, '1);
        send_item(REQ_PEEK, '0);
        send_item(REQ_SEARCH, '1);
        send_item(REQ_SEARCH, '0);
        send_item(REQ_DEQ, '0);
        send_item(REQ_DEQ, '0);

        // small ring: full, wrap on enqueue, search across the wrap, drain to empty
        write_capacity(5'd3);
        send_item(REQ_ENQ, 32'd5);
        send_item(REQ_ENQ, 32'd6);
        send_item(REQ_ENQ, 32'd5);
        send_item(REQ_ENQ, 32'd9);
        send_item(REQ_DEQ, '0);
        send_item(REQ_ENQ, 32'd5);
        send_item(REQ_SEARCH, 32'd5);
        send_item(REQ_DEQ, '0);
        send_item(REQ_DEQ, '0);
        send_item(REQ_DEQ, '0);
        send_item(REQ_DEQ, '0);
        send_item(REQ_ENQ, 32'h5555_AAAA);
        send_item(REQ_PEEK, '0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_capacity(phase_caps[ph]);
            tx_no_idle = (ph % 3 == 1);
            rx_no_idle = (ph % 4 == 2);
            if (ph == 3)
                hold_armed = 1'b1;
            cap_used = (phase_caps[ph] == 0) ? 1 :
                       (phase_caps[ph] > DEPTH) ? DEPTH : phase_caps[ph];
            // fill past capacity with few distinct words, then search for a word from the same range
            for (k = 0; k <= cap_used; k++)
                send_item(REQ_ENQ, $urandom_range(0, 3));
            send_item(REQ_SEARCH, $urandom_range(0, 3));
            for (k = cap_used + 2; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    op = REQ_ENQ;
                else if (r < 62)
                    op = REQ_DEQ;
                else if (r < 72)
                    op = REQ_PEEK;
                else
                    op = REQ_SEARCH;
                r = $urandom_range(0, 9);
                if (r < 4)
                    word = $urandom;
                else if (r < 7)
                    word = $urandom_range(0, 3);
                else
                    word = 32'hFFFF_FFFF - $urandom_range(0, 2);
                send_item(op, word);
            end
        end

        drain(20);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
